>>> design/lzrd_pkg.sv
// ----------------------------------------------------------------------------
// lzrd_pkg
// Shared types and constants of the LZMA range decoder: command codes,
// status codes and the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package lzrd_pkg;

   localparam int PROB_BITS = 11;
   localparam int MOVE_BITS = 5;
   localparam logic [PROB_BITS-1:0] PROB_INIT = 11'd1024;
   localparam logic [PROB_BITS:0] PROB_SCALE = 12'd2048;

   typedef enum logic [3:0] {
      CMD_FEED    = 4'd0,
      CMD_INIT    = 4'd1,
      CMD_BIT     = 4'd2,
      CMD_TREE    = 4'd3,
      CMD_REVERSE = 4'd4,
      CMD_DIRECT  = 4'd5,
      CMD_MATCHED = 4'd6,
      CMD_LENGTH  = 4'd7,
      CMD_CLEAR   = 4'd8
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_UNDERRUN = 2'd1,
      STAT_BAD_INIT = 2'd2,
      STAT_FULL     = 2'd3
   } stat_type;

   // probability address source
   typedef enum logic [1:0] {
      AM_CHOICE,
      AM_CHOICE2,
      AM_TREE,
      AM_MATCH
   } amode_type;

   // tree base source
   typedef enum logic [1:0] {
      TB_BASE,
      TB_LOW,
      TB_MID,
      TB_HIGH
   } tbase_type;

   typedef struct packed {
      logic      load;
      logic      push;
      logic      pop;
      logic      pop_shift;
      logic      range_ones;
      logic      cnt_dec;
      logic      sweep_start;
      logic      sweep_step;
      logic      mul;
      logic      upd;
      logic      dstep;
      logic      out_load;
      logic      set_underrun;
      logic      set_bad_init;
      logic      setup;
      tbase_type tb;
      amode_type am;
      logic [5:0] cnt;
      logic [5:0] nbits;
      logic [4:0] add;
      logic      rev;
   } ctl_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [5:0] n;
      logic       q_empty;
      logic       head_nz;
      logic       range_low;
      logic       cnt_zero;
      logic       cnt_one;
      logic       bit_val;
      logic       sweep_last;
   } sts_type;

endpackage

>>> design/lzrd_dpath.sv
// ----------------------------------------------------------------------------
// lzrd_dpath
// Range decoder datapath: coder range and code, probability memory, byte
// queue, tree node and counters, result register.
// ----------------------------------------------------------------------------
module lzrd_dpath import lzrd_pkg::*; #(
   parameter int PROB_ENTRIES   = 8192,
   parameter int QUEUE_DEPTH    = 16,
   parameter int MAX_POS_STATES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   output sts_type     st,
   input  logic [3:0]  command,
   input  logic [7:0]  data_byte,
   input  logic [12:0] prob_base,
   input  logic [5:0]  bit_count,
   input  logic [7:0]  ref_byte,
   input  logic [3:0]  len_slot,
   output logic [31:0] symbol,
   output logic [1:0]  status,
   output logic [4:0]  bytes_queued
);

   localparam int AW = $clog2(PROB_ENTRIES);
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   // command fields
   cmd_type     cmd_ff;
   logic [7:0]  dbyte_ff;
   logic [12:0] base_ff;
   logic [5:0]  n_ff;
   logic [7:0]  mbyte_ff;
   logic [3:0]  ps_ff;

   // coder
   logic [31:0] range_ff, range_in;
   logic [31:0] value_ff, value_in;
   logic [31:0] bound_ff;
   logic [PROB_BITS-1:0] rdata_ff;
   logic [32:0] m_ff;
   logic [5:0]  cnt_ff;
   logic [5:0]  nbits_ff;
   logic [4:0]  add_ff;
   logic        rev_ff;
   amode_type   am_ff;
   logic [AW-1:0] tbase_ff;
   logic [7:0]  mb_ff;
   logic        bit_ff;
   stat_type    stat_ff;
   logic [AW-1:0] sweep_ff;

   // probability memory
   logic [PROB_BITS-1:0] prob_mem [PROB_ENTRIES];

   // queue
   logic [7:0]    q_mem [QUEUE_DEPTH];
   logic [7:0]    head_ff;
   logic [QW-1:0] rp_ff, wp_ff;
   logic [FW-1:0] fill_ff;

   // result
   logic [31:0] rsp_sym_ff;
   logic [1:0]  rsp_stat_ff;
   logic [4:0]  rsp_bq_ff;

   logic [3:0]    psm;
   logic [AW-1:0] base_a, addr, tb_sel;
   logic          dec_zero;
   logic [PROB_BITS-1:0] p_new;
   logic [31:0]   half;
   logic          q_full;
   logic [31:0]   mask, masked, rev_all, sym_raw;

   // position state modulo the number of position states
   always_comb begin
      psm = '0;
      for (int k = 0; k < 16; k++) begin
         if (ps_ff == 4'(k)) psm = 4'(k % MAX_POS_STATES);
      end
   end

   // probability address
   assign base_a = AW'(base_ff);
   always_comb begin
      unique case (am_ff)
         AM_CHOICE:  addr = base_a;
         AM_CHOICE2: addr = base_a + AW'(1);
         AM_TREE:    addr = tbase_ff + m_ff[AW-1:0];
         AM_MATCH:   addr = base_a + (mb_ff[7] ? AW'(512) : AW'(256)) + m_ff[AW-1:0];
         default:    addr = base_a;
      endcase
   end

   always_comb begin
      unique case (ctl.tb)
         TB_BASE: tb_sel = base_a;
         TB_LOW:  tb_sel = base_a + AW'(2) + AW'({psm, 3'b000});
         TB_MID:  tb_sel = base_a + AW'(2 + 8 * MAX_POS_STATES) + AW'({psm, 3'b000});
         TB_HIGH: tb_sel = base_a + AW'(2 + 16 * MAX_POS_STATES);
         default: tb_sel = base_a;
      endcase
   end

   // bit decision and probability adaptation
   assign dec_zero = value_ff < bound_ff;
   always_comb begin
      if (dec_zero) begin
         p_new = PROB_BITS'(rdata_ff + PROB_BITS'((PROB_SCALE - {1'b0, rdata_ff}) >> MOVE_BITS));
      end else begin
         p_new = rdata_ff - (rdata_ff >> MOVE_BITS);
      end
   end
   assign half = range_ff >> 1;

   // probability memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.sweep_step) begin
         prob_mem[sweep_ff] <= PROB_INIT;
      end else if (ctl.upd) begin
         prob_mem[addr] <= p_new;
      end
      rdata_ff <= prob_mem[addr];
   end

   // byte queue storage and head read
   assign q_full = fill_ff == FW'(QUEUE_DEPTH);
   always_ff @(posedge clock) begin
      if (ctl.push && !q_full) q_mem[wp_ff] <= dbyte_ff;
      head_ff <= q_mem[rp_ff];
   end

   // coder range and code next values
   always_comb begin
      range_in = range_ff;
      value_in = value_ff;
      if (ctl.pop_shift) begin
         range_in = range_ff << 8;
         value_in = {value_ff[23:0], head_ff};
      end else if (ctl.range_ones) begin
         range_in = '1;
      end else if (ctl.upd) begin
         if (dec_zero) begin
            range_in = bound_ff;
         end else begin
            range_in = range_ff - bound_ff;
            value_in = value_ff - bound_ff;
         end
      end else if (ctl.dstep) begin
         range_in = half;
         if (value_ff >= half) value_in = value_ff - half;
      end
   end

   // control state: coder, queue pointers, sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= '1;
         value_ff <= '0;
         rp_ff    <= '0;
         wp_ff    <= '0;
         fill_ff  <= '0;
         sweep_ff <= '0;
      end else begin
         range_ff <= range_in;
         value_ff <= value_in;
         if (ctl.push && !q_full) begin
            wp_ff   <= (wp_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + QW'(1);
            fill_ff <= fill_ff + FW'(1);
         end else if (ctl.pop || ctl.pop_shift) begin
            rp_ff   <= (rp_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + QW'(1);
            fill_ff <= fill_ff - FW'(1);
         end
         if (ctl.sweep_start) begin
            sweep_ff <= '0;
         end else if (ctl.sweep_step) begin
            sweep_ff <= sweep_ff + AW'(1);
         end
      end
   end

   // command fields, tree walk and status
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= cmd_type'(command);
         dbyte_ff <= data_byte;
         base_ff  <= prob_base;
         n_ff     <= (bit_count > 6'd32) ? 6'd32 : bit_count;
         mbyte_ff <= ref_byte;
         ps_ff    <= len_slot;
         stat_ff  <= STAT_OK;
         nbits_ff <= '0;
         add_ff   <= '0;
         rev_ff   <= 1'b0;
      end
      if (ctl.setup) begin
         tbase_ff <= tb_sel;
         am_ff    <= ctl.am;
         cnt_ff   <= ctl.cnt;
         nbits_ff <= ctl.nbits;
         add_ff   <= ctl.add;
         rev_ff   <= ctl.rev;
         m_ff     <= 33'd1;
         mb_ff    <= mbyte_ff;
      end
      if (ctl.mul) bound_ff <= range_ff[31:11] * rdata_ff;
      if (ctl.upd) begin
         m_ff   <= {m_ff[31:0], !dec_zero};
         bit_ff <= !dec_zero;
         mb_ff  <= {mb_ff[6:0], 1'b0};
         // leave the match path on the first differing bit
         if (am_ff == AM_MATCH && mb_ff[7] == dec_zero) begin
            am_ff    <= AM_TREE;
            tbase_ff <= base_a;
         end
      end
      if (ctl.dstep) m_ff <= {m_ff[31:0], value_ff >= half};
      if (ctl.upd || ctl.dstep || ctl.cnt_dec) cnt_ff <= cnt_ff - 6'd1;
      if (ctl.push && q_full) stat_ff <= STAT_FULL;
      if (ctl.set_underrun) stat_ff <= STAT_UNDERRUN;
      if (ctl.set_bad_init) stat_ff <= STAT_BAD_INIT;
   end

   // symbol forming: mask, optional bit reversal, length offset
   assign mask   = (nbits_ff >= 6'd32) ? '1 : ((32'd1 << nbits_ff) - 32'd1);
   assign masked = m_ff[31:0] & mask;
   always_comb begin
      for (int k = 0; k < 32; k++) rev_all[k] = masked[31-k];
   end
   assign sym_raw = rev_ff ? (rev_all >> (6'd32 - nbits_ff)) : masked;

   // result register
   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_sym_ff  <= (stat_ff != STAT_OK || cmd_ff == CMD_INIT) ? '0 :
                        sym_raw + 32'(add_ff);
         rsp_stat_ff <= stat_ff;
         rsp_bq_ff   <= 5'(fill_ff);
      end
   end

   assign symbol       = rsp_sym_ff;
   assign status       = rsp_stat_ff;
   assign bytes_queued = rsp_bq_ff;

   assign st.cmd        = cmd_ff;
   assign st.n          = n_ff;
   assign st.q_empty    = fill_ff == '0;
   assign st.head_nz    = head_ff != 8'd0;
   assign st.range_low  = range_ff[31:24] == 8'd0;
   assign st.cnt_zero   = cnt_ff == 6'd0;
   assign st.cnt_one    = cnt_ff == 6'd1;
   assign st.bit_val    = bit_ff;
   assign st.sweep_last = sweep_ff == '1;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (ctl.pop || ctl.pop_shift) |-> fill_ff != '0)
      else $error("byte taken from an empty queue");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");
   a_bit_count: assert property (@(posedge clock) disable iff (reset)
      (ctl.upd || ctl.dstep) |-> cnt_ff != 6'd0)
      else $error("bit decoded past the requested count");

endmodule

>>> design/lzrd_ctrl.sv
// ----------------------------------------------------------------------------
// lzrd_ctrl
// Command sequencer: dispatches each item, steps the datapath one decoded bit
// at a time, sweeps the probability memory and holds the result handshake.
// ----------------------------------------------------------------------------
module lzrd_ctrl import lzrd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type st,
   output ctl_type ctl
);

   typedef enum logic [3:0] {
      ST_WIPE, ST_IDLE, ST_DISPATCH, ST_INIT, ST_IWAIT, ST_ISHIFT, ST_IEND,
      ST_RD, ST_MUL, ST_UPD, ST_DIR, ST_NORM, ST_NEXT, ST_CLEAR, ST_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] lstage_ff, lstage_in;
   logic       rsp_valid_ff;
   logic       out_go;

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign out_go     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      lstage_in = lstage_ff;
      ctl       = '0;
      ctl.tb    = TB_BASE;
      ctl.am    = AM_TREE;
      unique case (state_ff)
         ST_WIPE: begin
            ctl.sweep_step = 1'b1;
            if (st.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (st.cmd)
               CMD_FEED: begin
                  ctl.push = 1'b1;
                  state_in = ST_DONE;
               end
               CMD_INIT: state_in = ST_INIT;
               CMD_BIT: begin
                  ctl.setup = 1'b1;
                  ctl.am    = AM_CHOICE;
                  ctl.cnt   = 6'd1;
                  ctl.nbits = 6'd1;
                  state_in  = ST_RD;
               end
               CMD_TREE, CMD_REVERSE: begin
                  ctl.setup = 1'b1;
                  ctl.cnt   = st.n;
                  ctl.nbits = st.n;
                  ctl.rev   = st.cmd == CMD_REVERSE;
                  state_in  = (st.n == 6'd0) ? ST_DONE : ST_RD;
               end
               CMD_DIRECT: begin
                  ctl.setup = 1'b1;
                  ctl.cnt   = st.n;
                  ctl.nbits = st.n;
                  state_in  = (st.n == 6'd0) ? ST_DONE : ST_DIR;
               end
               CMD_MATCHED: begin
                  ctl.setup = 1'b1;
                  ctl.am    = AM_MATCH;
                  ctl.cnt   = 6'd8;
                  ctl.nbits = 6'd8;
                  state_in  = ST_RD;
               end
               CMD_LENGTH: begin
                  ctl.setup = 1'b1;
                  ctl.am    = AM_CHOICE;
                  ctl.cnt   = 6'd1;
                  lstage_in = 2'd0;
                  state_in  = ST_RD;
               end
               CMD_CLEAR: begin
                  ctl.sweep_start = 1'b1;
                  state_in        = ST_CLEAR;
               end
               default: state_in = ST_DONE;
            endcase
         end
         // check the marker byte, then load four code bytes
         ST_INIT: begin
            if (st.q_empty) begin
               ctl.set_underrun = 1'b1;
               state_in         = ST_DONE;
            end else if (st.head_nz) begin
               ctl.pop          = 1'b1;
               ctl.set_bad_init = 1'b1;
               state_in         = ST_DONE;
            end else begin
               ctl.pop   = 1'b1;
               ctl.setup = 1'b1;
               ctl.cnt   = 6'd4;
               state_in  = ST_IWAIT;
            end
         end
         ST_IWAIT: state_in = ST_ISHIFT;
         ST_ISHIFT: begin
            if (st.q_empty) begin
               ctl.set_underrun = 1'b1;
               state_in         = ST_DONE;
            end else begin
               ctl.pop_shift = 1'b1;
               ctl.cnt_dec   = 1'b1;
               state_in      = st.cnt_one ? ST_IEND : ST_IWAIT;
            end
         end
         ST_IEND: begin
            ctl.range_ones = 1'b1;
            state_in       = ST_DONE;
         end
         // one adaptive bit: read, multiply, decide, normalize
         ST_RD: state_in = ST_MUL;
         ST_MUL: begin
            ctl.mul  = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            ctl.upd  = 1'b1;
            state_in = ST_NORM;
         end
         ST_DIR: begin
            ctl.dstep = 1'b1;
            state_in  = ST_NORM;
         end
         ST_NORM: begin
            if (st.range_low && st.q_empty) begin
               ctl.set_underrun = 1'b1;
               state_in         = ST_DONE;
            end else begin
               ctl.pop_shift = st.range_low;
               if (st.cnt_zero) begin
                  state_in = ST_NEXT;
               end else begin
                  state_in = (st.cmd == CMD_DIRECT) ? ST_DIR : ST_RD;
               end
            end
         end
         // length coder: choice, second choice when the choice bit is one, then one of three trees
         ST_NEXT: begin
            state_in = ST_DONE;
            if (st.cmd == CMD_LENGTH) begin
               unique case (lstage_ff)
                  2'd0: begin
                     ctl.setup = 1'b1;
                     state_in  = ST_RD;
                     if (!st.bit_val) begin
                        ctl.tb    = TB_LOW;
                        ctl.cnt   = 6'd3;
                        ctl.nbits = 6'd3;
                        lstage_in = 2'd2;
                     end else begin
                        ctl.am    = AM_CHOICE2;
                        ctl.cnt   = 6'd1;
                        lstage_in = 2'd1;
                     end
                  end
                  2'd1: begin
                     ctl.setup = 1'b1;
                     state_in  = ST_RD;
                     lstage_in = 2'd2;
                     if (!st.bit_val) begin
                        ctl.tb    = TB_MID;
                        ctl.cnt   = 6'd3;
                        ctl.nbits = 6'd3;
                        ctl.add   = 5'd8;
                     end else begin
                        ctl.tb    = TB_HIGH;
                        ctl.cnt   = 6'd8;
                        ctl.nbits = 6'd8;
                        ctl.add   = 5'd16;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            ctl.sweep_step = 1'b1;
            if (st.sweep_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_go) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state, length stage and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         lstage_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         lstage_ff <= lstage_in;
         if (out_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the completion state");
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_DISPATCH)
      else $error("accepted item not dispatched");
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not delivered to a free output");

endmodule

>>> design/lzma_range_decoder.sv
// ----------------------------------------------------------------------------
// lzma_range_decoder
// LZMA adaptive binary range decoder with byte queue and probability memory.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the req_ channel is one command (req_tuser) with its operand
//   fields (req_tdata). Every command returns exactly one item on the rsp_
//   channel: decoded symbol, status and the queue fill after the command.
//   Feed pushes a compressed byte; init checks the zero marker byte and
//   loads four code bytes; the decode commands consume bytes as they
//   normalize. Underflow stops the command with status 1 and symbol zero.
// Sequencing: one item at a time; req_tready is high only while idle.
//   Bit, tree, reverse and matched decode each bit in read / multiply /
//   update / normalize steps through the probability memory port; direct
//   decodes each bit in a step and a normalize; clear sweeps all
//   PROB_ENTRIES probabilities.
// Reset: clears the coder and queue, then sweeps all PROB_ENTRIES
//   probabilities to 1024, one per cycle, before the first item is taken.
// Stall: a finished item waits in the output register; the next item is
//   accepted meanwhile and its result waits until that register is free.
// ----------------------------------------------------------------------------
module lzma_range_decoder import lzrd_pkg::*; #(
   parameter int PROB_ENTRIES   = 8192,
   parameter int QUEUE_DEPTH    = 16,
   parameter int MAX_POS_STATES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] data_byte, [20:8] prob_base, [26:21] bit_count,
   // [34:27] ref_byte, [38:35] len_slot, [39] zero
   input  logic [39:0] req_tdata,
   // [3:0] command
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] symbol, [33:32] status, [38:34] bytes_queued, [39] zero
   output logic [39:0] rsp_tdata
);

   ctl_type     ctl;
   sts_type     st;
   logic [31:0] symbol;
   logic [1:0]  status;
   logic [4:0]  bytes_queued;

   lzrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .ctl        (ctl)
   );

   lzrd_dpath #(
      .PROB_ENTRIES   (PROB_ENTRIES),
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .MAX_POS_STATES (MAX_POS_STATES)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .st           (st),
      .command      (req_tuser),
      .data_byte    (req_tdata[7:0]),
      .prob_base    (req_tdata[20:8]),
      .bit_count    (req_tdata[26:21]),
      .ref_byte     (req_tdata[34:27]),
      .len_slot     (req_tdata[38:35]),
      .symbol       (symbol),
      .status       (status),
      .bytes_queued (bytes_queued)
   );

   // pack the result item
   assign rsp_tdata = {1'b0, bytes_queued, status, symbol};

endmodule
